### rtl/kdsl_pkg.sv
// ----------------------------------------------------------------------------
// Key debounce package
// Shared payload types, register indexes and debounce constants for the
// short/long key press detector.
// ----------------------------------------------------------------------------
package kdsl_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS_LONG = 2'd1;

  // Reset value of the long press threshold in milliseconds
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1000;

  // Debounce mask patterns that declare a press and a release
  localparam logic [7:0] MASK_PRESS   = 8'h7f;
  localparam logic [7:0] MASK_RELEASE = 8'h01;

  // One scan sample
  typedef struct packed {
    logic        key_level;
    logic [31:0] now_ms;
  } in_t;

  // One result item
  typedef struct packed {
    logic       short_event;
    logic       long_event;
    logic [2:0] press_phase;
  } out_t;

  // Edges declared by the debouncer for the current sample
  typedef struct packed {
    logic press;
    logic release_evt;
  } deb_evt_t;

endpackage

### rtl/kdsl_debounce.sv
// ----------------------------------------------------------------------------
// Key debounce shift mask
// Holds the 8-bit debounce mask and declares press and release edges for the
// sample being processed.
// ----------------------------------------------------------------------------
module kdsl_debounce (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              held,
  output kdsl_pkg::deb_evt_t evt
);
  import kdsl_pkg::*;

  logic [7:0] mask_r;
  logic [7:0] mask_nxt;
  logic [7:0] mask_mid;

  // Pressed samples fill from the bottom and shift left, released samples
  // shift right. The edge is judged on the intermediate value.
  always_comb begin
    if (held) begin
      mask_mid        = mask_r | 8'h01;
      mask_nxt        = {mask_mid[6:0], 1'b0};
      evt.press       = (mask_mid == MASK_PRESS);
      evt.release_evt = 1'b0;
    end else begin
      mask_mid        = {1'b0, mask_r[7:1]};
      mask_nxt        = mask_mid;
      evt.press       = 1'b0;
      evt.release_evt = (mask_mid == MASK_RELEASE);
    end
  end

  // Mask register advances once per processed sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 8'h00;
    end else if (step) begin
      mask_r <= mask_nxt;
    end
  end

endmodule

### rtl/kdsl_phase.sv
// ----------------------------------------------------------------------------
// Key press phase machine
// Tracks the press phase and start time, and produces the short and long
// press events for each processed sample.
// ----------------------------------------------------------------------------
module kdsl_phase (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               held,
  input  logic [31:0]        now_ms,
  input  kdsl_pkg::deb_evt_t evt,
  input  logic [15:0]        long_press_ms,
  input  logic               continuous_long,
  output logic               short_ev,
  output logic               long_ev,
  output logic [2:0]         phase_out
);
  import kdsl_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_SHORT    = 3'd2,
    PH_LONG     = 3'd3,
    PH_RELEASED = 3'd4
  } phase_t;

  phase_t      phase_r;
  phase_t      phase_nxt;
  phase_t      phase_ovr;
  logic [31:0] start_r;
  logic [31:0] start_nxt;
  logic [31:0] elapsed;

  // Debouncer edges override the stored phase, and a press latches the start time.
  always_comb begin
    if (evt.release_evt) begin
      phase_ovr = PH_RELEASED;
    end else if (evt.press) begin
      phase_ovr = PH_PRESSED;
    end else begin
      phase_ovr = phase_r;
    end
    start_nxt = evt.press ? now_ms : start_r;
    elapsed   = now_ms - start_nxt;
  end

  // Phase transitions and events for this sample.
  always_comb begin
    phase_nxt = phase_ovr;
    short_ev  = 1'b0;
    long_ev   = 1'b0;
    unique case (phase_ovr)
      PH_PRESSED: begin
        phase_nxt = PH_SHORT;
      end
      PH_SHORT: begin
        if (held) begin
          if (elapsed >= {16'd0, long_press_ms}) begin
            phase_nxt = PH_LONG;
          end
        end else begin
          short_ev  = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (!continuous_long) begin
          phase_nxt = PH_IDLE;
        end
        long_ev = 1'b1;
      end
      PH_RELEASED: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = phase_ovr;
      end
    endcase
  end

  assign phase_out = phase_nxt;

  // Phase and start time registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      start_r <= 32'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
    end
  end

  // Transient phases are always resolved within the same sample.
  a_no_transient: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_PRESSED) && (phase_r != PH_RELEASED))
    else $error("transient press phase was stored");

  // A long event comes only from the long phase without a release that tick.
  a_long_src: assert property (@(posedge clk) disable iff (!rst_n)
    step && long_ev |-> (phase_r == PH_LONG) && !evt.release_evt)
    else $error("long event outside the long phase");

  // A short event always returns the machine to idle.
  a_short_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && short_ev |=> (phase_r == PH_IDLE))
    else $error("short event did not return to idle");

endmodule

### rtl/key_debounce_short_long_press.sv
// ----------------------------------------------------------------------------
// Key debounce with short and long press detection
// Top level: input register, debounce and phase logic, result register and
// the configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the in_ channel is one scan tick carrying the raw,
//   active-low key level and the current millisecond timestamp. Every tick
//   produces exactly one transfer on the out_ channel with the short and
//   long press events and the press phase after that tick.
//   A tick is captured in the input register and then processed into the
//   result register, where out_valid is raised. One tick is accepted per
//   cycle while the receiver is not stalling; the state update of the shift
//   mask and phase machine is a single registered pass per tick.
//   When the receiver stalls, the result register holds its item and the
//   input register holds the next one; in_ready drops only while both are
//   full, so no item is lost or repeated.
//   Reset (rst_n low, synchronous) empties both registers, clears the mask,
//   the phase and the start time, and sets the threshold to 1000 ms with
//   single-shot long events. Configuration writes are registered, and the user
//   must make them only while no tick is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kdsl_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kdsl_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [kdsl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kdsl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import kdsl_pkg::*;

  in_t         in_r;
  logic        in_valid_r;
  out_t        out_r;
  logic        out_valid_r;
  logic [15:0] long_press_ms_r;
  logic        continuous_long_r;
  logic        advance;
  logic        held;
  deb_evt_t    evt;
  logic        short_ev;
  logic        long_ev;
  logic [2:0]  phase_out;

  // A buffered tick is processed when the result register can take it.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign held      = !in_r.key_level;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.short_event <= short_ev;
      out_r.long_event  <= long_ev;
      out_r.press_phase <= phase_out;
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_ms_r   <= LONG_PRESS_MS_RST;
      continuous_long_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LONG_PRESS_MS) begin
        long_press_ms_r <= cfg_wdata[15:0];
      end else if (cfg_index == CFG_CONTINUOUS_LONG) begin
        continuous_long_r <= cfg_wdata[0];
      end
    end
  end

  kdsl_debounce u_debounce (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .held  (held),
    .evt   (evt)
  );

  kdsl_phase u_phase (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .held            (held),
    .now_ms          (in_r.now_ms),
    .evt             (evt),
    .long_press_ms   (long_press_ms_r),
    .continuous_long (continuous_long_r),
    .short_ev        (short_ev),
    .long_ev         (long_ev),
    .phase_out       (phase_out)
  );

endmodule
